@@ rtl/assert_macros.svh @@
// Assertion macros shared by the block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HBBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("hbbc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HBBC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("hbbc: next-cycle check failed");

`endif

@@ rtl/hbbc_pkg.sv @@
// ----------------------------------------------------------------------------
// hbbc_pkg
// Types and constants shared by the hashed block buffer cache modules.
// ----------------------------------------------------------------------------
`default_nettype none
package hbbc_pkg;

  localparam int BUFFERS = 30;
  localparam int BUCKETS = 13;
  localparam int IDX_W   = 5;
  localparam int BKT_W   = 4;
  localparam int CNT_W   = 5;

  localparam logic [IDX_W-1:0] NIL      = '1;
  localparam logic [IDX_W-1:0] IDX_LIM  = IDX_W'(BUFFERS);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(BUFFERS);
  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

  // Reciprocal of the bucket count, scaled by 2**MOD_SHIFT and rounded up.
  // It is exact for every dividend below 8192.
  localparam logic [13:0] MOD_RECIP = 14'd10083;
  localparam int          MOD_SHIFT = 17;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOFREE    = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_MOD   = 3'd2,
    OP_HOME  = 3'd3,
    OP_WALK  = 3'd4,
    OP_SINIT = 3'd5,
    OP_SCAN  = 3'd6,
    OP_FIN   = 3'd7
  } op_e;

  typedef struct packed {
    logic in_get;
    logic mod_last;
    logic walk_done;
    logic hit_now;
    logic ff_valid;
    logic scan_done;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/hbbc_dp.sv @@
// ----------------------------------------------------------------------------
// hbbc_dp
// Datapath: entry tables, bucket heads, modulo unit, list walker, result regs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hbbc_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [1:0]                   cmd_i,
  input  wire logic [7:0]                   device_i,
  input  wire logic [31:0]                  block_number_i,
  input  wire logic [4:0]                   buffer_slot_i,
  input  wire logic [31:0]                  now_tick_i,
  input  wire hbbc_pkg::op_e                op_i,
  output hbbc_pkg::stat_t                   stat_o,
  output logic [4:0]                        granted_slot_o,
  output logic                              was_hit_o,
  output logic                              must_read_o,
  output logic [1:0]                        status_o
);

  logic [7:0]                    dev_q    [hbbc_pkg::BUFFERS];
  logic [31:0]                   blk_q    [hbbc_pkg::BUFFERS];
  logic [7:0]                    refs_q   [hbbc_pkg::BUFFERS];
  logic                          valid_q  [hbbc_pkg::BUFFERS];
  logic [31:0]                   stamp_q  [hbbc_pkg::BUFFERS];
  logic [hbbc_pkg::IDX_W-1:0]    link_q   [hbbc_pkg::BUFFERS];
  logic [hbbc_pkg::IDX_W-1:0]    first_q  [hbbc_pkg::BUCKETS];

  hbbc_pkg::cmd_e              rcmd_q;
  logic [7:0]                  rdev_q;
  logic [31:0]                 rblk_q;
  logic [4:0]                  rslot_q;
  logic [31:0]                 rnow_q;
  logic [hbbc_pkg::BKT_W-1:0]  rem_q;
  logic [1:0]                  step_q;
  logic [13:0]                 fold_q;
  logic [hbbc_pkg::IDX_W-1:0]  cur_q, prev_q, tail_q, ff_q, hit_idx_q;
  logic [hbbc_pkg::IDX_W-1:0]  pick_q, pick_prev_q;
  logic [hbbc_pkg::BKT_W-1:0]  bkt_q, pick_bkt_q;
  logic [hbbc_pkg::CNT_W-1:0]  cnt_q;
  logic [31:0]                 best_q;
  logic                        ffv_q, hit_q, pickv_q;

  logic [13:0]                 fold_d;
  logic [12:0]                 fold_t;
  logic [26:0]                 quot_p;
  logic [8:0]                  quot;
  logic [12:0]                 rem_w;
  logic [hbbc_pkg::BKT_W-1:0]  rem_d;
  logic                        cur_nil, walk_end, match;
  logic [hbbc_pkg::IDX_W-1:0]  cur_idx, succ_cur, succ_pick, nb_head;
  logic [hbbc_pkg::BKT_W-1:0]  nb;
  logic                        take;

  // Remainder by 13 in three steps. Since 2**12 is 1 modulo 13, the 12-bit
  // chunks of the block number are summed, the sum is folded once more, and
  // a reciprocal multiplication finishes the small remainder.
  assign fold_d = 14'(rblk_q[11:0]) + 14'(rblk_q[23:12]) + 14'(rblk_q[31:24]);
  assign fold_t = 13'(fold_q[11:0]) + 13'(fold_q[13:12]);
  assign quot_p = 27'(fold_q[12:0]) * 27'(hbbc_pkg::MOD_RECIP);
  assign quot   = quot_p[hbbc_pkg::MOD_SHIFT+8:hbbc_pkg::MOD_SHIFT];
  assign rem_w  = fold_q[12:0] - 13'(quot) * 13'(hbbc_pkg::BUCKETS);
  assign rem_d  = rem_w[hbbc_pkg::BKT_W-1:0];

  assign cur_nil  = (cur_q >= hbbc_pkg::IDX_LIM);
  assign walk_end = cur_nil || (cnt_q == hbbc_pkg::CNT_MAX);
  assign cur_idx  = cur_nil ? '0 : cur_q;
  assign match    = !walk_end && (dev_q[cur_idx] == rdev_q) && (blk_q[cur_idx] == rblk_q);
  assign succ_cur = (link_q[cur_idx] >= hbbc_pkg::IDX_LIM) ? hbbc_pkg::NIL
                                                           : link_q[cur_idx];
  assign succ_pick = (link_q[pick_q] >= hbbc_pkg::IDX_LIM) ? hbbc_pkg::NIL
                                                           : link_q[pick_q];
  assign nb      = bkt_q + 1'b1;
  assign nb_head = (nb == rem_q || first_q[nb] >= hbbc_pkg::IDX_LIM) ? hbbc_pkg::NIL
                                                                      : first_q[nb];
  assign take    = (refs_q[cur_idx] == 8'd0) && (!pickv_q || stamp_q[cur_idx] < best_q);

  assign stat_o.in_get    = (cmd_i == hbbc_pkg::CMD_GET);
  assign stat_o.mod_last  = (step_q == 2'd0);
  assign stat_o.walk_done = walk_end || match;
  assign stat_o.hit_now   = match;
  assign stat_o.ff_valid  = ffv_q;
  assign stat_o.scan_done = walk_end && (bkt_q == hbbc_pkg::BKT_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hbbc_pkg::BUFFERS; i++) begin
        dev_q[i]   <= '0;
        blk_q[i]   <= '0;
        refs_q[i]  <= '0;
        valid_q[i] <= 1'b0;
        stamp_q[i] <= '0;
        link_q[i]  <= (i + 1 < hbbc_pkg::BUFFERS) ? hbbc_pkg::IDX_W'(i + 1) : hbbc_pkg::NIL;
      end
      for (int b = 0; b < hbbc_pkg::BUCKETS; b++) begin
        first_q[b] <= (b == 0) ? '0 : hbbc_pkg::NIL;
      end
      ffv_q   <= 1'b0;
      hit_q   <= 1'b0;
      pickv_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (op_i)
        hbbc_pkg::OP_LOAD: begin
          rcmd_q  <= hbbc_pkg::cmd_e'(cmd_i);
          rdev_q  <= device_i;
          rblk_q  <= block_number_i;
          rslot_q <= buffer_slot_i;
          rnow_q  <= now_tick_i;
          rem_q   <= '0;
          step_q  <= 2'd2;
          hit_q   <= 1'b0;
          ffv_q   <= 1'b0;
          pickv_q <= 1'b0;
        end
        hbbc_pkg::OP_MOD: begin
          case (step_q)
            2'd2: fold_q <= fold_d;
            2'd1: fold_q <= {1'b0, fold_t};
            default: rem_q <= rem_d;
          endcase
          step_q <= step_q - 2'd1;
        end
        hbbc_pkg::OP_HOME: begin
          cur_q  <= (first_q[rem_q] >= hbbc_pkg::IDX_LIM) ? hbbc_pkg::NIL : first_q[rem_q];
          cnt_q  <= '0;
          tail_q <= hbbc_pkg::NIL;
        end
        hbbc_pkg::OP_WALK: begin
          if (match) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cur_q;
          end else if (!walk_end) begin
            if (!ffv_q && refs_q[cur_idx] == 8'd0) begin
              ffv_q <= 1'b1;
              ff_q  <= cur_q;
            end
            tail_q <= cur_q;
            cur_q  <= succ_cur;
            cnt_q  <= cnt_q + 1'b1;
          end
        end
        hbbc_pkg::OP_SINIT: begin
          bkt_q  <= '0;
          cur_q  <= (rem_q == '0 || first_q[0] >= hbbc_pkg::IDX_LIM) ? hbbc_pkg::NIL
                                                                     : first_q[0];
          prev_q <= hbbc_pkg::NIL;
          cnt_q  <= '0;
        end
        hbbc_pkg::OP_SCAN: begin
          if (walk_end) begin
            if (bkt_q != hbbc_pkg::BKT_LAST) begin
              bkt_q  <= nb;
              cur_q  <= nb_head;
              prev_q <= hbbc_pkg::NIL;
              cnt_q  <= '0;
            end
          end else begin
            if (take) begin
              pickv_q     <= 1'b1;
              pick_q      <= cur_q;
              pick_prev_q <= prev_q;
              pick_bkt_q  <= bkt_q;
              best_q      <= stamp_q[cur_idx];
            end
            prev_q <= cur_q;
            cur_q  <= succ_cur;
            cnt_q  <= cnt_q + 1'b1;
          end
        end
        hbbc_pkg::OP_FIN: begin
          was_hit_o   <= 1'b0;
          must_read_o <= 1'b0;
          status_o    <= hbbc_pkg::ST_OK;
          granted_slot_o <= rslot_q;
          if (rcmd_q == hbbc_pkg::CMD_GET) begin
            if (hit_q) begin
              if (refs_q[hit_idx_q] != 8'hFF) refs_q[hit_idx_q] <= refs_q[hit_idx_q] + 8'd1;
              valid_q[hit_idx_q] <= 1'b1;
              was_hit_o      <= 1'b1;
              must_read_o    <= !valid_q[hit_idx_q];
              granted_slot_o <= hit_idx_q;
            end else if (ffv_q) begin
              dev_q[ff_q]    <= rdev_q;
              blk_q[ff_q]    <= rblk_q;
              refs_q[ff_q]   <= 8'd1;
              valid_q[ff_q]  <= 1'b1;
              must_read_o    <= 1'b1;
              granted_slot_o <= ff_q;
            end else if (pickv_q) begin
              // Unlink from the victim's bucket and append at the home tail.
              if (pick_prev_q == hbbc_pkg::NIL) first_q[pick_bkt_q] <= succ_pick;
              else link_q[pick_prev_q] <= succ_pick;
              link_q[pick_q] <= hbbc_pkg::NIL;
              if (tail_q == hbbc_pkg::NIL) first_q[rem_q] <= pick_q;
              else link_q[tail_q] <= pick_q;
              dev_q[pick_q]   <= rdev_q;
              blk_q[pick_q]   <= rblk_q;
              refs_q[pick_q]  <= 8'd1;
              valid_q[pick_q] <= 1'b1;
              must_read_o     <= 1'b1;
              granted_slot_o  <= pick_q;
            end else begin
              granted_slot_o <= '0;
              status_o       <= hbbc_pkg::ST_NOFREE;
            end
          end else if (rslot_q < hbbc_pkg::IDX_LIM) begin
            if (rcmd_q == hbbc_pkg::CMD_PIN) begin
              if (refs_q[rslot_q] != 8'hFF) refs_q[rslot_q] <= refs_q[rslot_q] + 8'd1;
            end else if (refs_q[rslot_q] == 8'd0) begin
              status_o <= hbbc_pkg::ST_UNDERFLOW;
            end else begin
              refs_q[rslot_q] <= refs_q[rslot_q] - 8'd1;
              if (rcmd_q == hbbc_pkg::CMD_RELEASE && refs_q[rslot_q] == 8'd1)
                stamp_q[rslot_q] <= rnow_q;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `HBBC_ASSERT_IMP(a_walk_bounded, clk_i, rst_ni, 1'b1, cnt_q <= hbbc_pkg::CNT_MAX)
  `HBBC_ASSERT_IMP(a_victim_not_home, clk_i, rst_ni, pickv_q, pick_bkt_q != rem_q)

endmodule
`default_nettype wire

@@ rtl/hbbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbbc_ctrl
// Controller: sequences one transaction through modulo, walk and scan phases.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hbbc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire hbbc_pkg::stat_t stat_i,
  output hbbc_pkg::op_e        op_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_HOME  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_SINIT = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       fin;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign fin         = (state_q == S_DONE) && (!ovalid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    op_o     = hbbc_pkg::OP_IDLE;
    ovalid_d = ovalid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = hbbc_pkg::OP_LOAD;
          state_d = stat_i.in_get ? S_MOD : S_DONE;
        end
      end
      S_MOD: begin
        op_o = hbbc_pkg::OP_MOD;
        if (stat_i.mod_last) state_d = S_HOME;
      end
      S_HOME: begin
        op_o    = hbbc_pkg::OP_HOME;
        state_d = S_WALK;
      end
      S_WALK: begin
        op_o = hbbc_pkg::OP_WALK;
        if (stat_i.walk_done) begin
          state_d = (stat_i.hit_now || stat_i.ff_valid) ? S_DONE : S_SINIT;
        end
      end
      S_SINIT: begin
        op_o    = hbbc_pkg::OP_SINIT;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        op_o = hbbc_pkg::OP_SCAN;
        if (stat_i.scan_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (fin) begin
          op_o     = hbbc_pkg::OP_FIN;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  `HBBC_ASSERT_NXT(a_mod_to_home, clk_i, rst_ni,
                   state_q == S_MOD && stat_i.mod_last, state_q == S_HOME)
  `HBBC_ASSERT_NXT(a_fin_presents, clk_i, rst_ni, fin, state_q == S_IDLE && ovalid_q)

endmodule
`default_nettype wire

@@ rtl/hashed_block_buffer_cache.sv @@
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache
// Pool of 30 block buffers in hashed linked lists with oldest-release reuse.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                               Direction
//   input     in_valid_i/in_ready_o, cmd, device, block, slot, tick  in
//   output    out_valid_o/out_ready_i, slot, hit, read, status       out
//
// Release, pin and unpin go from acceptance straight to the done state, which
// loads the result register. A get computes the modulo-13 hash, loads the
// home list head, then walks the home list one entry per cycle; a get that
// has to evict also scans every other bucket, one entry or one bucket change
// per cycle.
// Reset restores the initial list layout at once; no clearing pass is needed.
// One transaction is in flight at a time; a finished result waits in the
// output register while the next transaction is accepted and processed, and
// that next result is held back until the waiting one is taken.
`default_nettype none
module hashed_block_buffer_cache (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  device_i,
  input  wire logic [31:0] block_number_i,
  input  wire logic [4:0]  buffer_slot_i,
  input  wire logic [31:0] now_tick_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       granted_slot_o,
  output logic             was_hit_o,
  output logic             must_read_o,
  output logic [1:0]       status_o
);

  // Command and status between the controller and the datapath.
  hbbc_pkg::op_e   op;
  hbbc_pkg::stat_t stat;

  hbbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .op_o        (op)
  );

  // The datapath holds the entry tables and loads the result register
  // when the controller finishes a transaction.
  hbbc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .device_i       (device_i),
    .block_number_i (block_number_i),
    .buffer_slot_i  (buffer_slot_i),
    .now_tick_i     (now_tick_i),
    .op_i           (op),
    .stat_o         (stat),
    .granted_slot_o (granted_slot_o),
    .was_hit_o      (was_hit_o),
    .must_read_o    (must_read_o),
    .status_o       (status_o)
  );

endmodule
`default_nettype wire

@@ tb/hbbc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hbbc_checker
// Watches both channels of the buffer cache, keeps its own copy of the buffer
// lists, and compares every result transaction with the predicted one.
// ----------------------------------------------------------------------------
module hbbc_checker
  import hbbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  device_i,
  input  logic [31:0] block_number_i,
  input  logic [4:0]  buffer_slot_i,
  input  logic [31:0] now_tick_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [4:0]  granted_slot_i,
  input  logic        was_hit_i,
  input  logic        must_read_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NONE = 255;

  typedef struct packed {
    logic [4:0] slot;
    logic       hit;
    logic       rd;
    logic [1:0] status;
  } grant_t;

  logic [7:0]  buf_dev   [BUFFERS];
  logic [31:0] buf_blk   [BUFFERS];
  logic [7:0]  buf_refs  [BUFFERS];
  logic        buf_valid [BUFFERS];
  logic [31:0] buf_stamp [BUFFERS];
  int          buf_next  [BUFFERS];
  int          chain_head[BUCKETS];
  grant_t      grant_q[$];

  assign pending_o = grant_q.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  function automatic void lists_reset();
    for (int i = 0; i < BUFFERS; i++) begin
      buf_dev[i] = '0; buf_blk[i] = '0; buf_refs[i] = '0;
      buf_valid[i] = 1'b0; buf_stamp[i] = '0;
      buf_next[i] = (i + 1 < BUFFERS) ? i + 1 : NONE;
    end
    for (int b = 0; b < BUCKETS; b++) chain_head[b] = NONE;
    chain_head[0] = 0;
  endfunction

  function automatic grant_t lookup_block(logic [7:0] dev, logic [31:0] blk);
    grant_t g;
    int home, pick, pick_prev, pick_bkt, prev, i, n;
    logic [31:0] best;
    g = '0;
    home = blk % BUCKETS;
    pick = NONE; pick_prev = NONE; pick_bkt = 0; best = '0;
    for (i = chain_head[home], n = 0; i != NONE && n < BUFFERS; i = buf_next[i], n++)
      if (buf_dev[i] == dev && buf_blk[i] == blk) begin
        if (buf_refs[i] != 8'hFF) buf_refs[i]++;
        g.slot = i[4:0]; g.hit = 1'b1; g.rd = !buf_valid[i];
        buf_valid[i] = 1'b1;
        return g;
      end
    for (i = chain_head[home], n = 0; i != NONE && n < BUFFERS; i = buf_next[i], n++)
      if (buf_refs[i] == 0) begin
        pick = i;
        break;
      end
    if (pick == NONE) begin
      for (int b = 0; b < BUCKETS; b++) begin
        if (b == home) continue;
        prev = NONE;
        for (i = chain_head[b], n = 0; i != NONE && n < BUFFERS;
             prev = i, i = buf_next[i], n++)
          if (buf_refs[i] == 0 && (pick == NONE || buf_stamp[i] < best)) begin
            pick = i; pick_prev = prev; pick_bkt = b; best = buf_stamp[i];
          end
      end
      if (pick == NONE) begin
        g.status = ST_NOFREE;
        return g;
      end
      if (pick_prev == NONE) chain_head[pick_bkt] = buf_next[pick];
      else buf_next[pick_prev] = buf_next[pick];
      buf_next[pick] = NONE;
      prev = NONE;
      for (i = chain_head[home], n = 0; i != NONE && n < BUFFERS; i = buf_next[i], n++)
        prev = i;
      if (prev == NONE) chain_head[home] = pick;
      else buf_next[prev] = pick;
    end
    buf_dev[pick] = dev; buf_blk[pick] = blk; buf_refs[pick] = 8'd1;
    buf_valid[pick] = 1'b1;
    g.slot = pick[4:0]; g.rd = 1'b1;
    return g;
  endfunction

  function automatic grant_t apply_command(cmd_e c, logic [7:0] dev, logic [31:0] blk,
                                           logic [4:0] s, logic [31:0] tick);
    grant_t g;
    g = '0;
    g.slot = s;
    if (c == CMD_GET) return lookup_block(dev, blk);
    if (s < BUFFERS) begin
      if (c == CMD_PIN) begin
        if (buf_refs[s] != 8'hFF) buf_refs[s]++;
      end else if (buf_refs[s] == 0) begin
        g.status = ST_UNDERFLOW;
      end else begin
        buf_refs[s]--;
        if (c == CMD_RELEASE && buf_refs[s] == 0) buf_stamp[s] = tick;
      end
    end
    return g;
  endfunction

  initial begin
    fail_count_o = 0;
    lists_reset();
  end

  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (grant_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = grant_q.pop_front();
          if (granted_slot_i !== want.slot)
            report_mismatch("granted_slot", granted_slot_i, want.slot);
          if (was_hit_i !== want.hit) report_mismatch("was_hit", was_hit_i, want.hit);
          if (must_read_i !== want.rd) report_mismatch("must_read", must_read_i, want.rd);
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
        end
      end
      if (in_valid_i && in_ready_i)
        grant_q.push_back(apply_command(cmd_e'(cmd_i), device_i, block_number_i,
                                        buffer_slot_i, now_tick_i));
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the hashed block buffer cache: directed commands,
// then random get/release/pin/unpin traffic over a small block set.
// ----------------------------------------------------------------------------
module tb;
  import hbbc_pkg::*;

  localparam longint CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [7:0]  device_i = '0;
  logic [31:0] block_number_i = '0;
  logic [4:0]  buffer_slot_i = '0;
  logic [31:0] now_tick_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [4:0]  granted_slot_o;
  logic        was_hit_o;
  logic        must_read_o;
  logic [1:0]  status_o;
  int          fail_count;
  int          pending;

  // Idle percentages for each side; the phase sequence in the stimulus sets them.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  // When set, the receiver holds off completely for a long stretch.
  bit  recv_hold = 1'b0;
  longint cycle_count = 0;
  logic [31:0] tick_now = 32'd1;

  always #2 clk_i = ~clk_i;

  hashed_block_buffer_cache dut (.*);

  hbbc_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .device_i,
    .block_number_i, .buffer_slot_i, .now_tick_i, .out_valid_i(out_valid_o),
    .out_ready_i, .granted_slot_i(granted_slot_o), .was_hit_i(was_hit_o),
    .must_read_i(must_read_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // A cycle counter ends a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver's ready changes on the falling edge, like every other input.
  always @(negedge clk_i) begin
    if (recv_hold) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one transaction and hold it until the block accepts it. A random
  // idle gap comes first so that gaps fall on every phase of the block's work.
  // Valid stays high after acceptance only until the next call or drain, both
  // of which run at the same falling edge.
  task automatic send_cmd(input cmd_e c, input logic [7:0] dev, input logic [31:0] blk,
                          input logic [4:0] s, input logic [31:0] tick);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cmd_i <= c;
    device_i <= dev;
    block_number_i <= blk;
    buffer_slot_i <= s;
    now_tick_i <= tick;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    @(negedge clk_i);
  endtask

  // Pause until every predicted result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Random traffic. Gets come from a small device/block set so that hits,
  // bucket collisions and evictions all happen; releases, pins and unpins take
  // any slot number from 0 to 31, so out-of-range slots occur too.
  task automatic random_traffic(input int count);
    logic [31:0] blk;
    logic [7:0]  dev;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      tick_now = tick_now + $urandom_range(3);
      if ($urandom_range(19) == 0) tick_now = $urandom;
      if (pick < 45) begin
        blk = $urandom_range(40);
        if ($urandom_range(9) == 0) blk = $urandom;
        else if ($urandom_range(9) == 0) blk = 32'hFFFF_FFF0 + $urandom_range(15);
        dev = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1));
        send_cmd(CMD_GET, dev, blk, 5'($urandom), tick_now);
      end else if (pick < 75) begin
        send_cmd(CMD_RELEASE, 8'($urandom), $urandom, 5'($urandom_range(31)), tick_now);
      end else if (pick < 87) begin
        send_cmd(CMD_PIN, 8'($urandom), $urandom, 5'($urandom_range(31)), tick_now);
      end else begin
        send_cmd(CMD_UNPIN, 8'($urandom), $urandom, 5'($urandom_range(31)), tick_now);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: first get hits entry 0 in bucket zero's list and reads.
    send_cmd(CMD_GET, 8'h00, 32'd0, 5'd0, 32'd0);
    send_cmd(CMD_GET, 8'h00, 32'd0, 5'd0, 32'd0);
    send_cmd(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_cmd(CMD_GET, 8'hA5, 32'd13, 5'd0, 32'd0);
    // Release with the largest stamp, then underflow on a second release.
    send_cmd(CMD_RELEASE, 8'h00, 32'd0, 5'd1, 32'hFFFF_FFFF);
    send_cmd(CMD_RELEASE, 8'h00, 32'd0, 5'd1, 32'd5);
    send_cmd(CMD_UNPIN, 8'h00, 32'd0, 5'd29, 32'd7);
    // Out-of-range slots are ignored.
    send_cmd(CMD_PIN, 8'h00, 32'd0, 5'd30, 32'd0);
    send_cmd(CMD_RELEASE, 8'h00, 32'd0, 5'd31, 32'd0);
    send_cmd(CMD_UNPIN, 8'h00, 32'd0, 5'd31, 32'd0);
    // Pin then unpin: unpin never stamps.
    send_cmd(CMD_PIN, 8'h00, 32'd0, 5'd0, 32'd0);
    send_cmd(CMD_UNPIN, 8'h00, 32'd0, 5'd0, 32'h1234_5678);
    // Saturate one count at its ceiling.
    for (int k = 0; k < 256; k++) send_cmd(CMD_PIN, 8'h00, 32'd0, 5'd2, 32'd0);
    send_cmd(CMD_GET, 8'h00, 32'd0, 5'd0, 32'd0);
    // Fill the pool until no buffer is free; the last three gets then fail.
    for (int k = 0; k < 31; k++) send_cmd(CMD_GET, 8'h01, 32'(100 + k), 5'd0, 32'd0);
    // Free a few, two with the same stamp, so eviction picks the oldest.
    send_cmd(CMD_RELEASE, 8'h00, 32'd0, 5'd4, 32'd900);
    send_cmd(CMD_RELEASE, 8'h00, 32'd0, 5'd9, 32'd300);
    send_cmd(CMD_RELEASE, 8'h00, 32'd0, 5'd20, 32'd300);
    send_cmd(CMD_GET, 8'h07, 32'd777, 5'd0, 32'd0);
    send_cmd(CMD_GET, 8'h07, 32'd778, 5'd0, 32'd0);
    // Release every slot three times so random traffic starts with free buffers.
    for (int s = 0; s < BUFFERS; s++)
      for (int k = 0; k < 3; k++) send_cmd(CMD_RELEASE, 8'h00, 32'd0, 5'(s), 32'(s * 7));
    drain();

    // Phases of idling: none, sender idle, receiver stalling, both.
    send_idle_pct = 0;  recv_stall_pct = 0;  random_traffic(38);
    send_idle_pct = 65; recv_stall_pct = 0;  random_traffic(38);
    send_idle_pct = 0;  recv_stall_pct = 65; random_traffic(38);

    // Long receiver hold-off while the sender keeps offering transactions.
    fork
      begin
        recv_hold = 1'b1;
        repeat (600) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      random_traffic(10);
    join
    drain();

    send_idle_pct = 27; recv_stall_pct = 27; random_traffic(38);

    drain();
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
